### sv/mipbox_pkg.sv
// Shared types and constants for the mipmap box downsampler.
`default_nettype none

package mipbox_pkg;

   localparam int PIX_W      = 8;
   localparam int NUM_COLORS = 3;
   localparam int RGB_W      = NUM_COLORS * PIX_W;
   localparam int SUM_W      = 10;
   localparam int LINE_W     = NUM_COLORS * SUM_W;
   localparam int LEVEL_W    = 4;
   localparam int CFG_W      = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_WIDTH_LOG2  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT_LOG2 = 1'd1;

   localparam logic [CFG_W-1:0] CFG_LOG2_RESET = 4'd10;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_EXEC,
      ST_FLUSH
   } seq_state_type;

endpackage

`default_nettype wire

### sv/mipbox_line_ram.sv
// Line store of horizontal pair sums, one write and one registered read port.
`default_nettype none

module mipbox_line_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 30
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/mipbox_avg_unit.sv
// Shared adder: horizontal pair sums and truncated 2x2 means for all colors.
`default_nettype none

module mipbox_avg_unit (
   input  wire logic [mipbox_pkg::RGB_W-1:0]  left_pix,
   input  wire logic [mipbox_pkg::RGB_W-1:0]  new_pix,
   input  wire logic [mipbox_pkg::LINE_W-1:0] line_sums,
   output logic      [mipbox_pkg::LINE_W-1:0] pair_sums,
   output logic      [mipbox_pkg::RGB_W-1:0]  averages
);

   import mipbox_pkg::*;

   always_comb begin
      logic [SUM_W-1:0] pair;
      logic [SUM_W:0]   quad;
      pair_sums = '0;
      averages  = '0;
      for (int c = 0; c < NUM_COLORS; c++) begin
         pair = SUM_W'(left_pix[c*PIX_W +: PIX_W]) + SUM_W'(new_pix[c*PIX_W +: PIX_W]);
         // Two 8-bit values never carry past bit 8.
         pair[SUM_W-1] = 1'b0;
         quad = (SUM_W+1)'(line_sums[c*SUM_W +: SUM_W]) + (SUM_W+1)'(pair);
         pair_sums[c*SUM_W +: SUM_W] = pair;
         averages[c*PIX_W +: PIX_W]  = PIX_W'(quad >> 2);
      end
   end

endmodule

`default_nettype wire

### sv/mipmap_box_downsampler_top.sv
// Top level of the mipmap box downsampler: sequencer, per-level state and output register.
//
// Usage: base pixels enter on the req_ channel in raster order, one RGB pixel per beat.
// For each base pixel the block walks up the mipmap levels; every level whose 2x2
// block completes with this pixel yields one beat on the rsp_ channel, lowest level
// first, with rsp_tlast marking the last beat caused by that pixel. Most pixels yield
// no beat at all.
// Steps: a pixel is accepted, then each level it visits takes a registered line-store
// read followed by one pass through the shared adder; when the top level completes, a
// final flush step puts out its result. A result from an adder pass is registered as
// pending and moves to the rsp_ output register once that register is free.
// Stalls: one result waits in the output register; while the receiver holds
// rsp_tready low the sequencer waits before putting out the next one.
// Reset: all counters and left-pixel holds clear and both size registers return to 10. A
// csr_ write restarts the frame; the user must make it only when idle; not enforced.
`default_nettype none

module mipmap_box_downsampler_top #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_LEVELS = 10,
   parameter int CHANNELS   = 3
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // Fields from bit 0 up: red_in[7:0], green_in[15:8], blue_in[23:16].
   input  wire logic [mipbox_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // Fields from bit 0 up: level[3:0], red_out[11:4], green_out[19:12],
   // blue_out[27:20], zeros[31:28].
   output logic      [mipbox_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                                     rsp_tlast,
   input  wire logic                                csr_wr_en,
   input  wire logic [mipbox_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mipbox_pkg::CFG_W-1:0]        csr_wdata
);

   import mipbox_pkg::*;

   localparam int WL_MAX = $clog2(MAX_WIDTH + 1) - 1;
   localparam int AW     = $clog2(MAX_WIDTH);
   localparam int SW     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int CW     = WL_MAX;
   localparam int RW     = MAX_LEVELS;
   localparam int WL_LIM = (WL_MAX < MAX_LEVELS) ? WL_MAX : MAX_LEVELS;

   localparam logic [LEVEL_W-1:0] WL_LIM_L  = LEVEL_W'(WL_LIM);
   localparam logic [LEVEL_W-1:0] HL_LIM_L  = LEVEL_W'(MAX_LEVELS);
   localparam logic [LEVEL_W-1:0] ONE_L     = LEVEL_W'(1);
   localparam logic [AW-1:0]      IDX_MASK  = AW'(MAX_WIDTH - 1);

   // Configuration.
   logic [CFG_W-1:0]   width_raw_ff, height_raw_ff;
   logic [LEVEL_W-1:0] wl, hl, levels;
   logic               cfg_hit;

   // Sequencer.
   seq_state_type      state_ff, state_in;
   logic [LEVEL_W-1:0] s_ff;
   logic [SW-1:0]      sidx;
   logic [RGB_W-1:0]   px_ff;
   logic [RGB_W-1:0]   px_masked;

   // Per-level state.
   logic [CW-1:0]      col_ff  [MAX_LEVELS];
   logic [RW-1:0]      row_ff  [MAX_LEVELS];
   logic [RGB_W-1:0]   hold_ff [MAX_LEVELS];
   logic [CW-1:0]      cur_col, col_in;
   logic [RW-1:0]      cur_row, row_in;
   logic [CW:0]        w_val, col_inc;
   logic [RW:0]        h_val, row_inc;
   logic [AW:0]        base;
   logic [AW-1:0]      idx;
   logic [LEVEL_W-1:0] sh_w, sh_h;
   logic               stage_done;

   // Pending result and output register.
   logic               pend_valid_ff;
   logic [LEVEL_W-1:0] pend_level_ff;
   logic [RGB_W-1:0]   pend_rgb_ff;
   logic               rsp_valid_ff;
   logic [LEVEL_W-1:0] rsp_level_ff;
   logic [RGB_W-1:0]   rsp_rgb_ff;
   logic               rsp_last_ff;
   logic               slot_free;

   // Control from the state machine.
   logic               accept, stage_we, emit, emit_last, finish_stage, step_up;
   logic               ram_rd_en, ram_wr_en;

   // Datapath.
   logic [LINE_W-1:0]  line_rd, pair_sums;
   logic [RGB_W-1:0]   averages;

   assign cfg_hit = csr_wr_en &&
                    (csr_index == REG_WIDTH_LOG2 || csr_index == REG_HEIGHT_LOG2);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_raw_ff  <= CFG_LOG2_RESET;
         height_raw_ff <= CFG_LOG2_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == REG_WIDTH_LOG2) begin
            width_raw_ff <= csr_wdata;
         end else if (csr_index == REG_HEIGHT_LOG2) begin
            height_raw_ff <= csr_wdata;
         end
      end
   end

   // Saturate the size registers; the width is also held to what the line store fits.
   always_comb begin
      wl = width_raw_ff;
      if (wl < ONE_L) wl = ONE_L;
      if (wl > WL_LIM_L) wl = WL_LIM_L;
      hl = height_raw_ff;
      if (hl < ONE_L) hl = ONE_L;
      if (hl > HL_LIM_L) hl = HL_LIM_L;
      levels = (wl < hl) ? wl : hl;
   end

   always_comb begin
      px_masked = '0;
      for (int c = 0; c < NUM_COLORS; c++) begin
         if (c < CHANNELS) begin
            px_masked[c*PIX_W +: PIX_W] = req_tdata[c*PIX_W +: PIX_W];
         end
      end
   end

   // Position of the current level and its line-store entry.
   assign sidx    = s_ff[SW-1:0];
   assign cur_col = col_ff[sidx];
   assign cur_row = row_ff[sidx];
   assign sh_w    = wl - s_ff;
   assign sh_h    = hl - s_ff;
   assign w_val   = (CW+1)'(1) << sh_w;
   assign h_val   = (RW+1)'(1) << sh_h;
   assign base    = ((AW+1)'(1) << wl) - ((AW+1)'(1) << sh_w);
   assign idx     = AW'(base + (AW+1)'(cur_col >> 1)) & IDX_MASK;

   assign stage_done = cur_col[0] && cur_row[0];

   always_comb begin
      col_inc = (CW+1)'(cur_col) + (CW+1)'(1);
      row_inc = (RW+1)'(cur_row) + (RW+1)'(1);
      col_in  = col_inc[CW-1:0];
      row_in  = cur_row;
      if (col_inc >= w_val) begin
         col_in = '0;
         row_in = (row_inc == h_val) ? '0 : row_inc[RW-1:0];
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      accept       = 1'b0;
      stage_we     = 1'b0;
      emit         = 1'b0;
      emit_last    = 1'b0;
      finish_stage = 1'b0;
      step_up      = 1'b0;
      ram_rd_en    = 1'b0;
      ram_wr_en    = 1'b0;
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               accept   = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // The previous level's result is last unless this level completes too.
            ram_rd_en = 1'b1;
            if (!pend_valid_ff || slot_free) begin
               emit      = pend_valid_ff;
               emit_last = !stage_done;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            stage_we  = 1'b1;
            ram_wr_en = cur_col[0] && !cur_row[0];
            if (stage_done) begin
               finish_stage = 1'b1;
               if (s_ff + ONE_L < levels) begin
                  step_up  = 1'b1;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_FLUSH;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_last = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff <= px_masked;
      end else if (finish_stage) begin
         px_ff <= averages;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_ff <= '0;
      end else if (accept) begin
         s_ff <= '0;
      end else if (step_up) begin
         s_ff <= s_ff + ONE_L;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_hit) begin
         for (int i = 0; i < MAX_LEVELS; i++) begin
            col_ff[i]  <= '0;
            row_ff[i]  <= '0;
            hold_ff[i] <= '0;
         end
      end else if (stage_we) begin
         col_ff[sidx] <= col_in;
         row_ff[sidx] <= row_in;
         if (!cur_col[0]) begin
            hold_ff[sidx] <= px_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (finish_stage) begin
         pend_valid_ff <= 1'b1;
      end else if (emit) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_stage) begin
         pend_level_ff <= s_ff + ONE_L;
         pend_rgb_ff   <= averages;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_level_ff <= pend_level_ff;
         rsp_rgb_ff   <= pend_rgb_ff;
         rsp_last_ff  <= emit_last;
      end
   end

   mipbox_line_ram #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW),
      .DW    (LINE_W)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx),
      .wr_data (pair_sums),
      .rd_en   (ram_rd_en),
      .rd_addr (idx),
      .rd_data (line_rd)
   );

   mipbox_avg_unit u_avg_unit (
      .left_pix  (hold_ff[sidx]),
      .new_pix   (px_ff),
      .line_sums (line_rd),
      .pair_sums (pair_sums),
      .averages  (averages)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(RSP_DATA_W - LEVEL_W - RGB_W)'(0), rsp_rgb_ff, rsp_level_ff};

endmodule

`default_nettype wire

### sv/mipbox_checker.sv
// Port-level checks for the mipmap box downsampler, bound to its top level.
`default_nettype none

module mipbox_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [mipbox_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                              rsp_tlast
);

   import mipbox_pkg::*;

   // Nothing is shown on the result side right after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat valid right after reset");

   // A stalled result beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // The block works on one pixel at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken on two cycles in a row");

   // While a beat that is not the last of its pixel is shown, more are coming.
   a_no_accept_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input ready while a run of results is open");

   // Results always carry a level of one or more.
   a_level_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[LEVEL_W-1:0] != '0)
      else $error("result beat with level zero");

endmodule

bind mipmap_box_downsampler_top mipbox_checker u_mipbox_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
